### hw/rtl/dfms_pkg.sv
package dfms_pkg;

    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_BITS      = KEY_WORDS * 64;
    localparam int KEY_LEN_W     = 6;
    localparam int CNT_W         = 6;
    localparam int MIX_STEPS     = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int REQ_W         = 2;
    localparam int S_TDATA_W     = 232;
    localparam int M_TDATA_W     = 136;

    localparam logic [63:0] FNV_BASIS    = 64'd14695981039346656037;
    localparam logic [63:0] SECOND_TWEAK = 64'h9e3779b97f4a7c15;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_DATA  = 2'd1,
        REQ_END   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_MIX
    } state_t;

    typedef struct packed {
        logic start;
        logic key_step;
        logic mix_step;
        logic data_step;
        logic emit;
    } dfms_cmd_t;

    typedef struct packed {
        logic [KEY_LEN_W-1:0] key_len;
    } dfms_status_t;

    // multiply by the fnv prime 2^40 + 0x1b3 as shifts and adds
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b & BYTE_MASK};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

### hw/rtl/dfms_ctrl.sv
module dfms_ctrl
    import dfms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [REQ_W-1:0]   s_req,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dfms_status_t       status,
    output dfms_cmd_t          cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             open_reg, open_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             is_begin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign is_begin = (s_req == REQ_BEGIN);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_begin) begin
                    if (status.key_len != '0) begin
                        state_next = ST_KEY;
                        cnt_next   = status.key_len - CNT_W'(1);
                    end else begin
                        state_next = ST_MIX;
                        cnt_next   = CNT_W'(MIX_STEPS - 1);
                    end
                end
            end
            ST_KEY: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MIX;
                    cnt_next   = CNT_W'(MIX_STEPS - 1);
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_MIX: begin
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd            = '0;
        s_tready       = 1'b0;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                if (accept) begin
                    unique case (s_req)
                        REQ_BEGIN: begin
                            cmd.start = 1'b1;
                            open_next = 1'b1;
                        end
                        REQ_DATA: begin
                            cmd.data_step = open_reg;
                        end
                        REQ_END: begin
                            if (open_reg) begin
                                cmd.emit       = 1'b1;
                                open_next      = 1'b0;
                                out_valid_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_KEY: begin
                cmd.key_step = 1'b1;
            end
            ST_MIX: begin
                cmd.mix_step = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

### hw/rtl/dfms_datapath.sv
module dfms_datapath
    import dfms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [63:0]          cfg_wr_data,
    input  logic [31:0]          seq,
    input  logic [63:0]          nonce,
    input  logic [7:0]           data_byte,
    input  logic [63:0]          expected_hi,
    input  logic [63:0]          expected_lo,
    input  dfms_cmd_t            cmd,
    output dfms_status_t         status,
    output logic [63:0]          sig_hi,
    output logic [63:0]          sig_lo,
    output logic                 sig_match
);

    logic [63:0]          key_word_reg [KEY_WORDS];
    logic [KEY_LEN_W-1:0] key_length_reg;

    logic [KEY_BITS-1:0]  key_sr_reg;
    logic [95:0]          sn_first_reg;
    logic [95:0]          sn_second_reg;
    logic [63:0]          hash_first_reg, hash_first_next;
    logic [63:0]          hash_second_reg, hash_second_next;
    logic [63:0]          want_hi_reg;
    logic [63:0]          want_lo_reg;
    logic [63:0]          sig_hi_reg;
    logic [63:0]          sig_lo_reg;
    logic                 sig_match_reg;

    logic [7:0]           byte_first;
    logic [7:0]           byte_second;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_word_reg[i] <= '0;
            end
            key_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index) inside
                CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
                    key_word_reg[cfg_wr_index[1:0]] <= cfg_wr_data;
                end
                CFG_KEY_LENGTH: begin
                    key_length_reg <= cfg_wr_data[KEY_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // longer keys are cut to the maximum
    assign status.key_len = (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES))
                          ? KEY_LEN_W'(MAX_KEY_BYTES) : key_length_reg;

    always_comb begin
        byte_first  = data_byte;
        byte_second = data_byte;
        if (cmd.key_step) begin
            byte_first  = key_sr_reg[KEY_BITS-1 -: 8];
            byte_second = key_sr_reg[KEY_BITS-1 -: 8];
        end else if (cmd.mix_step) begin
            byte_first  = sn_first_reg[95:88];
            byte_second = sn_second_reg[95:88];
        end
    end

    always_comb begin
        hash_first_next  = hash_first_reg;
        hash_second_next = hash_second_reg;
        if (cmd.start) begin
            hash_first_next  = FNV_BASIS;
            hash_second_next = FNV_BASIS ^ SECOND_TWEAK;
        end else if (cmd.key_step || cmd.mix_step || cmd.data_step) begin
            hash_first_next  = fnv_absorb(hash_first_reg, byte_first);
            hash_second_next = fnv_absorb(hash_second_reg, byte_second);
        end
    end

    always_ff @(posedge aclk) begin
        hash_first_reg  <= hash_first_next;
        hash_second_reg <= hash_second_next;
        if (cmd.start) begin
            key_sr_reg    <= {key_word_reg[0], key_word_reg[1],
                              key_word_reg[2], key_word_reg[3]};
            sn_first_reg  <= {seq, nonce};
            sn_second_reg <= {nonce, seq};
            want_hi_reg   <= expected_hi;
            want_lo_reg   <= expected_lo;
        end else begin
            if (cmd.key_step) begin
                key_sr_reg <= key_sr_reg << 8;
            end
            if (cmd.mix_step) begin
                sn_first_reg  <= sn_first_reg << 8;
                sn_second_reg <= sn_second_reg << 8;
            end
        end
        if (cmd.emit) begin
            sig_hi_reg    <= hash_first_reg;
            sig_lo_reg    <= hash_second_reg;
            sig_match_reg <= (hash_first_reg == want_hi_reg) &&
                             (hash_second_reg == want_lo_reg);
        end
    end

    assign sig_hi    = sig_hi_reg;
    assign sig_lo    = sig_lo_reg;
    assign sig_match = sig_match_reg;

endmodule

### hw/rtl/dual_fnv1a_message_signer.sv
// payload transaction: both hashes updated in the cycle of acceptance, if a message is open
// end transaction: result in the output register in the cycle after acceptance, if a message is open
// begin transaction: key_length key bytes (up to 32), then 12 seq/nonce bytes, one byte per cycle through
// one shift-and-add absorb unit per hash; no transaction is taken meanwhile
// synchronous active-low reset clears key registers, key length, open flag and m_tvalid
module dual_fnv1a_message_signer
    import dfms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [63:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // seq, nonce, data_byte, expected_hi, expected_lo
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sig_hi, sig_lo, sig_match, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    dfms_cmd_t    cmd;
    dfms_status_t status;
    logic [63:0]  sig_hi;
    logic [63:0]  sig_lo;
    logic         sig_match;

    dfms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dfms_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .seq          (s_tdata[31:0]),
        .nonce        (s_tdata[95:32]),
        .data_byte    (s_tdata[103:96]),
        .expected_hi  (s_tdata[167:104]),
        .expected_lo  (s_tdata[231:168]),
        .cmd          (cmd),
        .status       (status),
        .sig_hi       (sig_hi),
        .sig_lo       (sig_lo),
        .sig_match    (sig_match)
    );

    assign m_tdata = {7'd0, sig_match, sig_lo, sig_hi};

endmodule
